// ----- rtl/core/rbd_pkg.sv -----
// Shared types and codes for the ring buffer deque unit.
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OCC_W   = 5;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                  operation;
        logic [VALUE_W-1:0]   push_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]   pop_value;
        logic                 success;
        logic [OCC_W-1:0]     occupancy;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec;
        logic take_read;
    } t_cmd;

    typedef struct packed {
        logic pop_ok;
    } t_status;

endpackage

// ----- rtl/core/rbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rbd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/rbd_ctrl.sv -----
// Control state machine: accepts a beat, runs it, times the result strobe.
`timescale 1ns / 1ps

module rbd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  rbd_pkg::t_status i_status,
    output rbd_pkg::t_cmd  o_cmd,
    output logic           busy,
    output logic           o_strobe
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    always_comb begin
        o_cmd.capture   = start & ~r_busy;
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.take_read = (r_state == S_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (i_status.pop_ok) begin
                        r_state <= S_READ;
                    end else begin
                        r_state  <= S_IDLE;
                        r_busy   <= 1'b0;
                        r_strobe <= 1'b1;
                    end
                end
                S_READ: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

endmodule

// ----- rtl/core/rbd_datapath.sv -----
// Datapath: item register, ring indices, element count, store and result register.
`timescale 1ns / 1ps

module rbd_datapath #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbd_pkg::t_cmd      i_cmd,
    input  rbd_pkg::t_in_item  i_item,
    output rbd_pkg::t_status   o_status,
    output rbd_pkg::t_out_item o_result
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned VW = rbd_pkg::VALUE_W;
    localparam int unsigned OW = rbd_pkg::OCC_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rbd_pkg::t_in_item  r_item;
    rbd_pkg::t_out_item r_result;
    logic [IW-1:0]      r_front;
    logic [IW-1:0]      r_back;
    logic [CW-1:0]      r_count;

    logic              is_push;
    logic              ok;
    logic [IW-1:0]     front_inc;
    logic [IW-1:0]     front_dec;
    logic [IW-1:0]     back_inc;
    logic [IW-1:0]     back_dec;
    logic [CW-1:0]     n_count;
    logic [CW+OW-1:0]  occ_ext;
    logic [VW+DATA_WIDTH-1:0] wr_ext;
    logic [DATA_WIDTH+VW-1:0] rd_ext;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    always_comb begin
        is_push   = (r_item.operation == rbd_pkg::OP_PUSH_BACK) ||
                    (r_item.operation == rbd_pkg::OP_PUSH_FRONT);
        ok        = is_push ? (r_count != FULL_CNT) : (r_count != '0);
        front_inc = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
        front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
        back_inc  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;
        back_dec  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;
        n_count   = is_push ? r_count + 1'b1 : r_count - 1'b1;
        if (!ok) begin
            n_count = r_count;
        end
        occ_ext = {{OW{1'b0}}, n_count};
        wr_ext  = {{DATA_WIDTH{1'b0}}, r_item.push_value};
        rd_ext  = {{VW{1'b0}}, rd_data};

        wr_en   = i_cmd.exec & ok & is_push;
        wr_addr = (r_item.operation == rbd_pkg::OP_PUSH_FRONT) ? front_dec : r_back;
        rd_en   = i_cmd.exec & ok & ~is_push;
        rd_addr = (r_item.operation == rbd_pkg::OP_POP_BACK) ? back_dec : r_front;

        o_status.pop_ok = ok & ~is_push;
    end

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_ext[DATA_WIDTH-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec && ok) begin
            r_count <= n_count;
            unique case (r_item.operation)
                rbd_pkg::OP_PUSH_BACK:  r_back  <= back_inc;
                rbd_pkg::OP_PUSH_FRONT: r_front <= front_dec;
                rbd_pkg::OP_POP_BACK:   r_back  <= back_dec;
                rbd_pkg::OP_POP_FRONT:  r_front <= front_inc;
                default:                r_front <= r_front;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_result.pop_value <= '0;
            r_result.success   <= ok;
            r_result.occupancy <= occ_ext[OW-1:0];
        end
        if (i_cmd.take_read) begin
            r_result.pop_value <= rd_ext[VW-1:0];
        end
    end

    assign o_result = r_result;

endmodule

// ----- rtl/core/ring_buffer_deque_unit.sv -----
// Top level of the ring buffer deque unit: controller plus datapath.
`timescale 1ns / 1ps

// Double-ended queue over a ring store of DEPTH entries of DATA_WIDTH bits.
// Input: drive i_item (operation, push_value) and raise start; the beat is
// taken at a clock edge where start is high and busy is low.
// Operations: push back, push front, pop back, pop front. A push on a full
// queue or a pop on an empty one fails, leaves the state alone and returns
// zero; pushes always return zero in pop_value.
// Output: one result per beat on o_result, valid for the single cycle in
// which o_strobe is high. The receiver cannot stall; it must take it then.
// Each beat runs in S_EXEC, which registers success and occupancy into
// o_result; pushes and failed pops then raise o_strobe, while a successful
// pop first passes through S_READ, which takes the registered store read.
// busy drops in the strobe cycle, so a new beat can be accepted in that
// cycle; no new beat is taken while one is running.
// Reset (i_rst_n low, synchronous) empties the queue; the store contents
// are left as they are and are only read after a push has written them.
module ring_buffer_deque_unit #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  rbd_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output rbd_pkg::t_out_item o_result
);

    rbd_pkg::t_cmd    cmd;
    rbd_pkg::t_status status;

    rbd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    rbd_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_status (status),
        .o_result (o_result)
    );

endmodule

// ----- tb/tb_ring_buffer_deque_unit.sv -----
// Self-checking testbench for the ring buffer deque unit: mirrored deque predictor, directed and random beats.
`timescale 1ns / 1ps

module tb_ring_buffer_deque_unit;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned IDX_W      = $clog2(DEPTH);
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          MAX_GAP        = 20;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    rbd_pkg::t_in_item  i_item  = '0;
    logic               busy;
    logic               o_strobe;
    rbd_pkg::t_out_item o_result;

    ring_buffer_deque_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // mirror of the deque state
    logic [rbd_pkg::VALUE_W-1:0] mirror_store [DEPTH];
    logic [IDX_W-1:0]            mirror_front;
    logic [IDX_W-1:0]            mirror_back;
    logic [rbd_pkg::OCC_W-1:0]   mirror_count;

    rbd_pkg::t_out_item pending_results [$];
    rbd_pkg::t_out_item oldest_result;

    int error_count     = 0;
    int beats_sent      = 0;
    int results_checked = 0;
    int full_rejects    = 0;
    int empty_rejects   = 0;
    int peak_occupancy  = 0;
    int quiet_cycles    = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic rbd_pkg::t_out_item deque_result(input rbd_pkg::t_in_item beat);
        rbd_pkg::t_out_item res;
        res = '0;
        case (beat.operation)
            rbd_pkg::OP_PUSH_BACK, rbd_pkg::OP_PUSH_FRONT: begin
                if (int'(mirror_count) < DEPTH) begin
                    if (beat.operation == rbd_pkg::OP_PUSH_BACK) begin
                        mirror_store[mirror_back] = beat.push_value;
                        mirror_back = mirror_back + 1'b1;
                    end else begin
                        mirror_front = mirror_front - 1'b1;
                        mirror_store[mirror_front] = beat.push_value;
                    end
                    mirror_count = mirror_count + 1'b1;
                    res.success = 1'b1;
                end else begin
                    full_rejects++;
                end
            end
            default: begin
                if (mirror_count != '0) begin
                    if (beat.operation == rbd_pkg::OP_POP_BACK) begin
                        mirror_back = mirror_back - 1'b1;
                        res.pop_value = mirror_store[mirror_back];
                    end else begin
                        res.pop_value = mirror_store[mirror_front];
                        mirror_front = mirror_front + 1'b1;
                    end
                    mirror_count = mirror_count - 1'b1;
                    res.success = 1'b1;
                end else begin
                    empty_rejects++;
                end
            end
        endcase
        res.occupancy = mirror_count;
        if (int'(mirror_count) > peak_occupancy) peak_occupancy = int'(mirror_count);
        return res;
    endfunction

    function automatic logic [rbd_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic rbd_pkg::t_op pick_op(input int push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? rbd_pkg::OP_PUSH_FRONT : rbd_pkg::OP_PUSH_BACK;
        return $urandom_range(1) ? rbd_pkg::OP_POP_FRONT : rbd_pkg::OP_POP_BACK;
    endfunction

    // Drive one beat, hold it until taken, then idle for a random gap.
    task automatic send_beat(input rbd_pkg::t_op op,
                             input logic [rbd_pkg::VALUE_W-1:0] value,
                             input int idle_pct);
        rbd_pkg::t_in_item beat;
        int                gap;
        beat.operation  = op;
        beat.push_value = value;
        gap = 0;
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(deque_result(beat));
        beats_sent++;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_pops();
        send_beat(rbd_pkg::OP_POP_FRONT, '1, 0);
        send_beat(rbd_pkg::OP_POP_BACK, 32'h8000_0001, 0);
    endtask

    task automatic test_fill_to_full();
        for (int k = 0; k < DEPTH; k++) begin
            case (k % 4)
                0: send_beat(rbd_pkg::OP_PUSH_BACK, '1, 0);
                1: send_beat(rbd_pkg::OP_PUSH_FRONT, '0, 0);
                2: send_beat(rbd_pkg::OP_PUSH_BACK, 32'hA5A5_5A5A ^ k, 0);
                default: send_beat(rbd_pkg::OP_PUSH_FRONT, 32'h5A5A_A5A5 ^ (k << 24), 0);
            endcase
        end
        send_beat(rbd_pkg::OP_PUSH_BACK, 32'hDEAD_0001, 0);
        send_beat(rbd_pkg::OP_PUSH_FRONT, 32'hDEAD_0002, 0);
    endtask

    task automatic test_pops_both_ends();
        send_beat(rbd_pkg::OP_POP_FRONT, '0, 0);
        send_beat(rbd_pkg::OP_POP_BACK, '0, 0);
        send_beat(rbd_pkg::OP_POP_FRONT, '1, 0);
        send_beat(rbd_pkg::OP_POP_BACK, '1, 0);
    endtask

    // Runs of push-heavy, pop-heavy, balanced and random-mix traffic sweep the occupancy.
    task automatic test_random_traffic(input int count, input int idle_pct);
        int sent;
        int run_len;
        int push_pct;
        sent = 0;
        while (sent < count) begin
            run_len = $urandom_range(8, 40);
            case ($urandom_range(3))
                0:       push_pct = 85;
                1:       push_pct = 15;
                2:       push_pct = 50;
                default: push_pct = $urandom_range(100);
            endcase
            for (int k = 0; k < run_len && sent < count; k++) begin
                send_beat(pick_op(push_pct), pick_value(), idle_pct);
                sent++;
            end
        end
    endtask

    task automatic test_pause_until_drained();
        for (int r = 0; r < 5; r++) begin
            test_random_traffic(30, 24);
            wait_drained();
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no pending beat");
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                if (o_result.pop_value !== oldest_result.pop_value) begin
                    $error("pop_value: expected %h, got %h",
                           oldest_result.pop_value, o_result.pop_value);
                    error_count++;
                end
                if (o_result.success !== oldest_result.success) begin
                    $error("success: expected %b, got %b",
                           oldest_result.success, o_result.success);
                    error_count++;
                end
                if (o_result.occupancy !== oldest_result.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           oldest_result.occupancy, o_result.occupancy);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        mirror_front = '0;
        mirror_back  = '0;
        mirror_count = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pops();
        test_fill_to_full();
        test_pops_both_ends();
        test_random_traffic(200, 0);
        test_random_traffic(200, 55);
        test_random_traffic(200, 24);
        test_pause_until_drained();

        wait_drained();
        repeat (5) @(posedge i_clk);

        $display("Ran %0d beats, checked %0d results, peak occupancy %0d of %0d.",
                 beats_sent, results_checked, peak_occupancy, DEPTH);
        $display("Rejected pushes on full queue: %0d, rejected pops on empty queue: %0d.",
                 full_rejects, empty_rejects);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rbd_pkg.sv
rtl/core/rbd_ram.sv
rtl/core/rbd_ctrl.sv
rtl/core/rbd_datapath.sv
rtl/core/ring_buffer_deque_unit.sv
tb/tb_ring_buffer_deque_unit.sv
